>>> rtl/core/md5_pkg.sv
// ----------------------------------------------------------------------------
// md5_pkg
// shared constants, types and round tables of the md5 stream hasher
// ----------------------------------------------------------------------------
package md5_pkg;

  // initial chaining words
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LENGTH_AT  = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [5:0] LAST_BYTE  = 6'd63;

  // how the message words of a block are formed on read
  typedef enum logic [1:0] {
    BLK_DATA,      // stored bytes as they are
    BLK_PAD,       // stored bytes, pad byte, zeros, bit length
    BLK_PAD_ONLY,  // stored bytes, pad byte, zeros to block end
    BLK_LEN_ONLY   // zeros and bit length
  } blk_kind_t;

  // controls from the sequencer to the round datapath
  typedef struct packed {
    logic       load;     // copy chaining words into working words
    logic       calc;     // first half of a round
    logic       step;     // second half of a round
    logic       fold;     // add working words into chaining words
    logic       restart;  // chaining words back to initial values
    logic [5:0] round;
  } rnd_ctl_t;

  function automatic logic [31:0] md5_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // rotate amount, four per group of sixteen rounds
  function automatic logic [4:0] md5_rot(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by a round
  function automatic logic [3:0] md5_msg_idx(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] idx;
    lo = r[3:0];
    case (r[5:4])
      2'd0:    idx = lo;
      2'd1:    idx = 4'(lo * 4'd5 + 4'd1);
      2'd2:    idx = 4'(lo * 4'd3 + 4'd5);
      default: idx = 4'(lo * 4'd7);
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/core/md5_msg_buf.sv
// ----------------------------------------------------------------------------
// md5_msg_buf
// block store of 16 message words with byte writes, registered word read
// and padding applied on the read side
// ----------------------------------------------------------------------------
module md5_msg_buf import md5_pkg::*; (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [5:0]  wr_addr,
  input  logic [7:0]  wr_byte,
  input  logic [3:0]  rd_addr,
  input  blk_kind_t   kind,
  input  logic [5:0]  fill,
  input  logic [63:0] bit_len,
  output logic [31:0] msg_word
);

  logic [31:0] mem [16];
  logic [31:0] rd_data;
  logic [3:0]  rd_idx;
  logic [31:0] merged;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[5:2]][{wr_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  // word that holds the fill point: bytes below it, pad byte, then zeros
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < fill[1:0]) begin
        merged[k*8 +: 8] = rd_data[k*8 +: 8];
      end else if (2'(k) == fill[1:0]) begin
        merged[k*8 +: 8] = PAD_BYTE;
      end else begin
        merged[k*8 +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    case (kind)
      BLK_DATA: begin
        msg_word = rd_data;
      end
      BLK_PAD, BLK_PAD_ONLY: begin
        if (kind == BLK_PAD && rd_idx == 4'd14) begin
          msg_word = bit_len[31:0];
        end else if (kind == BLK_PAD && rd_idx == 4'd15) begin
          msg_word = bit_len[63:32];
        end else if (rd_idx < fill[5:2]) begin
          msg_word = rd_data;
        end else if (rd_idx == fill[5:2]) begin
          msg_word = merged;
        end else begin
          msg_word = 32'h0;
        end
      end
      default: begin
        if (rd_idx == 4'd14) begin
          msg_word = bit_len[31:0];
        end else if (rd_idx == 4'd15) begin
          msg_word = bit_len[63:32];
        end else begin
          msg_word = 32'h0;
        end
      end
    endcase
  end

endmodule

>>> rtl/core/md5_round.sv
// ----------------------------------------------------------------------------
// md5_round
// chaining words, working words and the md5 round in two halves (calc, step)
// ----------------------------------------------------------------------------
module md5_round import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rnd_ctl_t    ctl,
  input  logic [31:0] msg_word,
  output logic [31:0] sum_a,
  output logic [31:0] sum_b,
  output logic [31:0] sum_c,
  output logic [31:0] sum_d
);

  logic [31:0] ch_a, ch_b, ch_c, ch_d;
  logic [31:0] va, vb, vc, vd;
  logic [31:0] t;
  logic [31:0] mix;
  logic [63:0] rot_wide;

  always_comb begin
    case (ctl.round[5:4])
      2'd0:    mix = (vb & vc) | (~vb & vd);
      2'd1:    mix = (vb & vd) | (vc & ~vd);
      2'd2:    mix = vb ^ vc ^ vd;
      default: mix = vc ^ (vb | ~vd);
    endcase
  end

  assign rot_wide = {t, t} << md5_rot(ctl.round);

  assign sum_a = ch_a + va;
  assign sum_b = ch_b + vb;
  assign sum_c = ch_c + vc;
  assign sum_d = ch_d + vd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_a <= IV_A;
      ch_b <= IV_B;
      ch_c <= IV_C;
      ch_d <= IV_D;
    end else if (ctl.fold) begin
      ch_a <= sum_a;
      ch_b <= sum_b;
      ch_c <= sum_c;
      ch_d <= sum_d;
    end else if (ctl.restart) begin
      ch_a <= IV_A;
      ch_b <= IV_B;
      ch_c <= IV_C;
      ch_d <= IV_D;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      va <= ch_a;
      vb <= ch_b;
      vc <= ch_c;
      vd <= ch_d;
    end
    if (ctl.calc) begin
      t <= va + mix + md5_k(ctl.round) + msg_word;
    end
    if (ctl.step) begin
      va <= vd;
      vd <= vc;
      vc <= vb;
      vb <= vb + rot_wide[63:32];
    end
  end

endmodule

>>> rtl/core/md5_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// md5_stream_hasher_core
// streaming md5: at most one message byte per transfer, digest after the end mark
// ----------------------------------------------------------------------------
// compression: each block runs through one read setup, 64 rounds of a calc half
//   and a step half, and one fold in the round unit; in_stall is high throughout
//   and while a digest waits for the output; the digest follows the end-marked
//   transfer after one compression, or two when the padding spills or that byte completes a block
// throughput: no bytes are taken while a block is being compressed
// reset: synchronous rst loads the initial chaining words, clears fill point,
//   byte count and output valid; the block store is not cleared
module md5_stream_hasher_core import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] word_a,
  output logic [31:0] word_b,
  output logic [31:0] word_c,
  output logic [31:0] word_d
);

  typedef enum logic [2:0] {
    S_IDLE,   // taking bytes
    S_PREP,   // read of the first message word in flight
    S_CALC,   // first half of a round
    S_STEP,   // second half of a round, next word read issued
    S_FOLD    // chaining update or digest hand-off
  } state_t;

  state_t      state;
  logic [5:0]  fill;          // bytes held in the block store
  logic [60:0] byte_cnt;      // message length in bytes, wraps
  blk_kind_t   kind;          // how the current block is read
  logic [5:0]  round;
  logic        tail_pending;  // end mark seen with a full block, padding still due

  logic        accept;
  logic [5:0]  fill_inc;
  logic [5:0]  fill_after;
  logic        block_full;
  logic        final_blk;
  logic        out_free;
  logic [3:0]  rd_addr;
  logic [31:0] msg_word;
  logic [31:0] sum_a, sum_b, sum_c, sum_d;
  rnd_ctl_t    ctl;

  // input transfers only while no compression is running
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign fill_inc   = fill + 6'd1;
  assign fill_after = has_byte ? fill_inc : fill;
  assign block_full = has_byte && (fill == LAST_BYTE);

  // the last block of a message ends in the bit length
  assign final_blk = (kind == BLK_PAD) || (kind == BLK_LEN_ONLY);
  // output slot free now or freed by the transfer at this edge
  assign out_free  = !out_valid || !out_stall;

  // prefetch: word for round 0 in setup, word for the next round in each step
  assign rd_addr = (state == S_STEP) ? md5_msg_idx(round + 6'd1) : md5_msg_idx(6'd0);

  always_comb begin
    ctl.load    = (state == S_PREP);
    ctl.calc    = (state == S_CALC);
    ctl.step    = (state == S_STEP);
    ctl.fold    = (state == S_FOLD) && !final_blk;
    ctl.restart = (state == S_FOLD) && final_blk && out_free;
    ctl.round   = round;
  end

  md5_msg_buf u_buf (
    .clk      (clk),
    .wr_en    (accept && has_byte),
    .wr_addr  (fill),
    .wr_byte  (data_byte),
    .rd_addr  (rd_addr),
    .kind     (kind),
    .fill     (fill),
    .bit_len  ({byte_cnt, 3'b000}),
    .msg_word (msg_word)
  );

  md5_round u_round (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .msg_word (msg_word),
    .sum_a    (sum_a),
    .sum_b    (sum_b),
    .sum_c    (sum_c),
    .sum_d    (sum_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= 6'd0;
      byte_cnt     <= 61'd0;
      kind         <= BLK_DATA;
      round        <= 6'd0;
      tail_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // digest taken downstream, unless a new one is loaded at this edge
      if (out_valid && !out_stall && !ctl.restart) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (has_byte) begin
              byte_cnt <= byte_cnt + 61'd1;
              fill     <= fill_inc;
            end
            if (block_full) begin
              // full block first, padding after it if the end mark came along
              kind         <= BLK_DATA;
              tail_pending <= last;
              state        <= S_PREP;
            end else if (last) begin
              // no room for the length after the pad byte: spill into a second block
              kind  <= (fill_after >= LENGTH_AT) ? BLK_PAD_ONLY : BLK_PAD;
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          round <= 6'd0;
          state <= S_CALC;
        end
        S_CALC: begin
          state <= S_STEP;
        end
        S_STEP: begin
          round <= round + 6'd1;
          state <= (round == LAST_ROUND) ? S_FOLD : S_CALC;
        end
        S_FOLD: begin
          case (kind)
            BLK_DATA: begin
              if (tail_pending) begin
                kind         <= BLK_PAD;
                tail_pending <= 1'b0;
                state        <= S_PREP;
              end else begin
                state <= S_IDLE;
              end
            end
            BLK_PAD_ONLY: begin
              kind  <= BLK_LEN_ONLY;
              state <= S_PREP;
            end
            default: begin
              // hold here until the output register can take the digest
              if (out_free) begin
                out_valid <= 1'b1;
                word_a    <= sum_a;
                word_b    <= sum_b;
                word_c    <= sum_c;
                word_d    <= sum_d;
                fill      <= 6'd0;
                byte_cnt  <= 61'd0;
                kind      <= BLK_DATA;
                state     <= S_IDLE;
              end
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/md5_digest_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// watches both channels of the md5 stream hasher, predicts every digest
// from the accepted bytes and compares it with the digest that comes out
// ----------------------------------------------------------------------------
module md5_digest_checker import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] word_a,
  input  logic [31:0] word_b,
  input  logic [31:0] word_c,
  input  logic [31:0] word_d,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic [31:0] round_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, four per group of sixteen rounds
  int unsigned rot_sh [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                               4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0] chain_w [4];
  logic [7:0]  frame_bytes [64];
  int          frame_fill;
  logic [63:0] bit_total;
  digest_t     digest_q [$];
  int          n_fail = 0;
  int          n_checked = 0;

  task automatic restart_state();
    chain_w[0] = IV_A;
    chain_w[1] = IV_B;
    chain_w[2] = IV_C;
    chain_w[3] = IV_D;
    frame_fill = 0;
    bit_total  = '0;
  endtask

  task automatic compress_frame();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, sum, hold;
    int          r, grp, idx;
    int unsigned s;
    for (r = 0; r < 16; r++)
      m[r] = {frame_bytes[4*r+3], frame_bytes[4*r+2],
              frame_bytes[4*r+1], frame_bytes[4*r]};
    a = chain_w[0];
    b = chain_w[1];
    c = chain_w[2];
    d = chain_w[3];
    for (r = 0; r < 64; r++) begin
      grp = r / 16;
      case (grp)
        0: begin
          f = (b & c) | (~b & d);
          idx = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          idx = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          idx = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          idx = (7 * r) % 16;
        end
      endcase
      sum  = a + f + round_k[r] + m[idx];
      s    = rot_sh[grp * 4 + r % 4];
      hold = d;
      d    = c;
      c    = b;
      b    = b + ((sum << s) | (sum >> (32 - s)));
      a    = hold;
    end
    chain_w[0] = chain_w[0] + a;
    chain_w[1] = chain_w[1] + b;
    chain_w[2] = chain_w[2] + c;
    chain_w[3] = chain_w[3] + d;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    frame_bytes[frame_fill] = v;
    frame_fill++;
    bit_total = bit_total + 64'd8;
    if (frame_fill == 64) begin
      compress_frame();
      frame_fill = 0;
    end
  endtask

  // pad, append the bit length (spilling into a second frame when needed)
  task automatic close_message(output digest_t dg);
    int i;
    frame_bytes[frame_fill] = PAD_BYTE;
    for (i = frame_fill + 1; i < 64; i++)
      frame_bytes[i] = 8'h00;
    if (frame_fill >= int'(LENGTH_AT)) begin
      compress_frame();
      for (i = 0; i < 64; i++)
        frame_bytes[i] = 8'h00;
    end
    for (i = 0; i < 8; i++)
      frame_bytes[int'(LENGTH_AT) + i] = bit_total[8*i +: 8];
    compress_frame();
    dg = '{chain_w[0], chain_w[1], chain_w[2], chain_w[3]};
    restart_state();
  endtask

  task automatic check_word(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    digest_t dg;
    if (rst) begin
      restart_state();
      digest_q.delete();
    end else begin
      // result side first: a digest never leaves in the cycle its end mark arrives
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest transfer, expected none, actual %h %h %h %h",
                   $time, word_a, word_b, word_c, word_d);
          n_fail++;
        end else begin
          dg = digest_q.pop_front();
          check_word("word_a", dg.a, word_a);
          check_word("word_b", dg.b, word_b);
          check_word("word_c", dg.c, word_c);
          check_word("word_d", dg.d, word_d);
          n_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        if (has_byte)
          absorb_byte(data_byte);
        if (last) begin
          close_message(dg);
          digest_q.push_back(dg);
        end
      end
    end
    fail_count <= n_fail;
    pending    <= digest_q.size();
    checked    <= n_checked;
  end

endmodule

>>> tb/md5_stream_hasher_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// md5_stream_hasher_core_tb
// drives message bytes into the md5 hasher with bursty timing and a
// randomly stalling digest receiver; a separate checker predicts and
// compares every digest, this module makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module md5_stream_hasher_core_tb;

  // generous cap on the run length in cycles
  localparam int CYCLE_LIMIT = 3000000;
  // long receiver hold-off so the core fills up and stalls its input
  localparam int HOLDOFF_CYCLES = 3000;
  // worst case drain: two compressions plus margin
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 1800;
  localparam int MIN_MESSAGES = 45;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        has_byte = 1'b0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;

  int fail_count;
  int pending;
  int checked;

  // stimulus bookkeeping, used for the stop condition and the summary
  int burst_left = 0;
  int n_items = 0;
  int n_msgs = 0;
  int n_bytes = 0;
  int n_bare = 0;
  int n_spill = 0;
  int msg_fill = 0;
  int cycles = 0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  md5_stream_hasher_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .word_a    (word_a),
    .word_b    (word_b),
    .word_c    (word_c),
    .word_d    (word_d)
  );

  md5_digest_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .has_byte   (has_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_a     (word_a),
    .word_b     (word_b),
    .word_c     (word_c),
    .word_d     (word_d),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  // one input transfer; the sender runs in bursts with idle gaps between them.
  // valid is only dropped at the start of a gap, so it never gets two
  // nonblocking writes in one step
  task automatic send_item(input logic [7:0] b, input logic h, input logic l);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(200, 60)
                                            : $urandom_range(16, 1);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    has_byte  <= h;
    last      <= l;
    // hold the payload until the core takes it
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (h || l)
      n_items++;
    else
      n_bare++;
    if (h) begin
      n_bytes++;
      msg_fill++;
    end
    if (l) begin
      // pad and length no longer fit in the current block
      if (msg_fill % 64 >= 56)
        n_spill++;
      msg_fill = 0;
      n_msgs++;
    end
  endtask

  // random message content with occasional bare markers mixed in;
  // the end mark rides on the final byte or comes as a bare end item
  task automatic send_message(input int len, input bit bare_end);
    int k;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(15) == 0)
        send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (k == len - 1) && !bare_end);
    end
    if (bare_end || len == 0)
      send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // stimulus: directed corner cases, then random messages
  initial begin
    int len;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, a bare end mark alone
    send_item(8'hff, 1'b0, 1'b1);
    // bare item changes nothing, the digest is still the empty one
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    // single byte carrying its own end mark, both byte extremes
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // classic three-byte message
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // bytes, a bare item, then a separate bare end item
    send_item(8'h55, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h3c, 1'b0, 1'b1);

    // random part: lengths cluster around the padding-spill window and the
    // block boundaries, with short messages for frequent restarts
    while (n_items < RANDOM_ITEMS || n_msgs < MIN_MESSAGES) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: len = $urandom_range(15);
        9, 10, 11, 12, 13:         len = $urandom_range(68, 52);
        14, 15, 16:                len = $urandom_range(130, 118);
        default:                   len = $urandom_range(200);
      endcase
      send_message(len, $urandom_range(3) == 0);
    end
    in_valid <= 1'b0;

    // wait for every predicted digest, then let the core settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d messages, %0d message bytes, %0d bare markers, %0d padding spills",
             n_msgs, n_bytes, n_bare, n_spill);
    $display("%0d digests compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("** md5_stream_hasher_core: PASSED **");
    end else begin
      $display("** md5_stream_hasher_core: FAILED **");
    end
    $finish;
  end

  // receiver: stall phases of random length and density, plus one long
  // hold-off once a few digests have gone through
  initial begin
    int phase_len;
    int pct;
    int held;
    bit done_holdoff;
    done_holdoff = 1'b0;
    @(negedge rst);
    forever begin
      phase_len = $urandom_range(200, 20);
      case ($urandom_range(3))
        0:       pct = 0;
        1:       pct = 30;
        2:       pct = 60;
        default: pct = 90;
      endcase
      repeat (phase_len) begin
        out_stall <= ($urandom_range(99) < pct);
        @(posedge clk);
      end
      if (!done_holdoff && checked >= 8) begin
        // sender keeps offering items while the digest path is blocked
        out_stall <= 1'b1;
        held = 0;
        while (held < HOLDOFF_CYCLES) begin
          @(posedge clk);
          held++;
        end
        done_holdoff = 1'b1;
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d digests still expected", cycles, pending);
    $display("** md5_stream_hasher_core: FAILED **");
    $finish;
  end

endmodule
